>>> hw/rtl/mpbm_pkg.sv
// Shared types, command codes and default sizes for the multi-pattern byte matcher.
// No dependencies; every other file of the block refers to it by scoped names.
package mpbm_pkg;

    // Default sizes handed to the top level parameters
    localparam int DEF_NODES            = 256;
    localparam int DEF_MATCHES_PER_NODE = 8;
    localparam int DEF_PATTERN_IDS      = 256;
    localparam int DEF_POSITION_BITS    = 32;

    // Input beat command codes
    localparam logic [2:0] CMD_SCAN   = 3'd0;
    localparam logic [2:0] CMD_START  = 3'd1;
    localparam logic [2:0] CMD_GOTO   = 3'd2;
    localparam logic [2:0] CMD_FAIL   = 3'd3;
    localparam logic [2:0] CMD_APPEND = 3'd4;

    // One input beat
    typedef struct packed {
        logic [2:0] command;
        logic [7:0] node_index;
        logic [7:0] byte_value;
        logic [7:0] target_node;
        logic [7:0] pattern_id;
    } t_in_beat;

    // One result beat
    typedef struct packed {
        logic [31:0] position;
        logic [7:0]  pattern_id_found;
        logic        last_match;
    } t_out_beat;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_step;     // clear one table entry of the sweep
        logic accept;       // input beat taken this cycle
        logic take_child;   // move to the child just read
        logic follow_fail;  // move along the failure link just read
        logic force_root;   // failure walk ran too long, back to root
        logic emit;         // load the result register
        logic scan_done;    // byte finished, advance the position
        logic app_write;    // commit a pending match id append
    } t_ctl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic       clr_last;
        logic [2:0] in_cmd;
        logic       child_nz;
        logic       cur_zero;
        logic       steps_max;
        logic       cnt_zero;
        logic       last_k;
        logic       out_free;
        logic       app_ok;
    } t_ctl_sts;

endpackage

>>> hw/rtl/multi_pattern_byte_matcher_core.sv
// Top level of the multi-pattern byte matcher: controller plus datapath.
// Depends on mpbm_pkg, mpbm_ctrl and mpbm_datapath.
//
// Aho-Corasick scanner over a byte stream with host-loaded node tables. After reset the
// block runs a clearing pass over the goto table (one entry a cycle, also zeroing
// failure links and match counts) and stalls its input until done. A scan beat reads
// the goto and failure entries of the current node from the registered memories,
// follows failure links until a child is found or the root is reached (forced back to
// the root if the walk runs too long), then reads the pattern ids one at a time from
// the match list memory, waiting while the result register is stalled. Start, goto
// write and failure write beats are done when taken; an append first reads the count,
// then writes. One beat is processed at a time; a new beat is taken while the last
// result still waits in the output register.
module multi_pattern_byte_matcher_core #(
    parameter int NODES            = mpbm_pkg::DEF_NODES,
    parameter int MATCHES_PER_NODE = mpbm_pkg::DEF_MATCHES_PER_NODE,
    parameter int PATTERN_IDS      = mpbm_pkg::DEF_PATTERN_IDS,
    parameter int POSITION_BITS    = mpbm_pkg::DEF_POSITION_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mpbm_pkg::t_in_beat  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mpbm_pkg::t_out_beat o_out
);

    mpbm_pkg::t_ctl_cmd ctl_cmd;
    mpbm_pkg::t_ctl_sts ctl_sts;

    // Sequencer
    mpbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (ctl_sts),
        .o_cmd      (ctl_cmd)
    );

    // Tables and walk registers
    mpbm_datapath #(
        .NODES            (NODES),
        .MATCHES_PER_NODE (MATCHES_PER_NODE),
        .PATTERN_IDS      (PATTERN_IDS),
        .POSITION_BITS    (POSITION_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .i_cmd       (ctl_cmd),
        .o_sts       (ctl_sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

>>> hw/rtl/mpbm_ctrl.sv
// Controller state machine of the multi-pattern byte matcher.
// Depends on mpbm_pkg for command codes and the command and status structs.
module mpbm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mpbm_pkg::t_ctl_sts i_sts,
    output mpbm_pkg::t_ctl_cmd o_cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_GCHK  = 3'd2;
    localparam logic [2:0] ST_LIST  = 3'd3;
    localparam logic [2:0] ST_APP   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Beats are taken only when idle
    assign o_in_stall = (r_state != ST_IDLE);

    // Next state and commands
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    unique case (i_sts.in_cmd)
                        mpbm_pkg::CMD_SCAN:   n_state = ST_GCHK;
                        mpbm_pkg::CMD_APPEND: n_state = ST_APP;
                        default:              n_state = ST_IDLE;
                    endcase
                end
            end
            ST_GCHK: begin
                // goto and failure entries of the current node are on the read ports
                if (i_sts.child_nz) begin
                    o_cmd.take_child = 1'b1;
                    n_state          = ST_LIST;
                end else if (i_sts.cur_zero) begin
                    n_state = ST_LIST;
                end else if (i_sts.steps_max) begin
                    o_cmd.force_root = 1'b1;
                end else begin
                    o_cmd.follow_fail = 1'b1;
                end
            end
            ST_LIST: begin
                if (i_sts.cnt_zero) begin
                    o_cmd.scan_done = 1'b1;
                    n_state         = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last_k) begin
                        o_cmd.scan_done = 1'b1;
                        n_state         = ST_IDLE;
                    end
                end
            end
            ST_APP: begin
                o_cmd.app_write = i_sts.app_ok;
                n_state         = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register; reset starts the table clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hw/rtl/mpbm_datapath.sv
// Datapath of the multi-pattern byte matcher: node tables, walk registers, result register.
// Depends on mpbm_pkg; driven by mpbm_ctrl through the command and status structs.
module mpbm_datapath #(
    parameter int NODES            = mpbm_pkg::DEF_NODES,
    parameter int MATCHES_PER_NODE = mpbm_pkg::DEF_MATCHES_PER_NODE,
    parameter int PATTERN_IDS      = mpbm_pkg::DEF_PATTERN_IDS,
    parameter int POSITION_BITS    = mpbm_pkg::DEF_POSITION_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mpbm_pkg::t_in_beat  i_in,
    input  logic                i_out_stall,
    input  mpbm_pkg::t_ctl_cmd  i_cmd,
    output mpbm_pkg::t_ctl_sts  o_sts,
    output logic                o_out_valid,
    output mpbm_pkg::t_out_beat o_out
);

    localparam int NW = $clog2(NODES);
    localparam int GA = NW + 8;
    localparam int GD = NODES * 256;
    localparam int LD = NODES * MATCHES_PER_NODE;
    localparam int LA = $clog2(LD);
    localparam int CW = $clog2(MATCHES_PER_NODE + 1);
    localparam int SW = $clog2(NODES + 1);

    // Table memories
    logic [NW-1:0] goto_mem [GD];
    logic [NW-1:0] fail_mem [NODES];
    logic [CW-1:0] cnt_mem  [NODES];
    logic [7:0]    list_mem [LD];

    // Walk and control registers
    logic [NW-1:0]            r_cur,   n_cur;
    logic [POSITION_BITS-1:0] r_pos;
    logic [CW-1:0]            r_k,     n_k;
    logic [SW-1:0]            r_steps;
    logic [GA-1:0]            r_clr;
    logic [7:0]               r_byte,  n_byte;
    logic [NW-1:0]            r_node;
    logic                     r_node_ok;
    logic [7:0]               r_pid;
    logic                     r_pid_ok;
    logic                     r_out_valid;
    mpbm_pkg::t_out_beat      r_out;

    // Registered read data
    logic [NW-1:0] goto_rd;
    logic [NW-1:0] fail_rd;
    logic [CW-1:0] cnt_rd;
    logic [7:0]    list_rd;

    // Input field decode
    logic [NW+7:0] in_node_x, in_tgt_x;
    logic [NW-1:0] in_node, in_tgt;
    logic          in_node_ok, in_tgt_ok, in_pid_ok;
    logic          acc_start, acc_goto, acc_fail, acc_app;

    assign in_node_x  = {{NW{1'b0}}, i_in.node_index};
    assign in_tgt_x   = {{NW{1'b0}}, i_in.target_node};
    assign in_node    = in_node_x[NW-1:0];
    assign in_tgt     = in_tgt_x[NW-1:0];
    assign in_node_ok = 32'(i_in.node_index) < 32'(NODES);
    assign in_tgt_ok  = 32'(i_in.target_node) < 32'(NODES);
    assign in_pid_ok  = 32'(i_in.pattern_id) < 32'(PATTERN_IDS);

    assign acc_start = i_cmd.accept && (i_in.command == mpbm_pkg::CMD_START);
    assign acc_goto  = i_cmd.accept && (i_in.command == mpbm_pkg::CMD_GOTO);
    assign acc_fail  = i_cmd.accept && (i_in.command == mpbm_pkg::CMD_FAIL);
    assign acc_app   = i_cmd.accept && (i_in.command == mpbm_pkg::CMD_APPEND);

    // Next walk values; reads are addressed with them so data lines up next cycle
    always_comb begin
        n_cur = r_cur;
        if (acc_start || i_cmd.force_root) begin
            n_cur = '0;
        end else if (i_cmd.take_child) begin
            n_cur = goto_rd;
        end else if (i_cmd.follow_fail) begin
            n_cur = fail_rd;
        end
    end

    always_comb begin
        n_k = r_k;
        if (i_cmd.accept) begin
            n_k = '0;
        end else if (i_cmd.emit) begin
            n_k = r_k + CW'(1);
        end
    end

    assign n_byte = i_cmd.accept ? i_in.byte_value : r_byte;

    // Addresses and write controls
    logic [GA-1:0] goto_raddr, goto_waddr;
    logic [NW-1:0] goto_wdata, fail_wdata, fail_waddr, cnt_raddr, cnt_waddr;
    logic [CW-1:0] cnt_wdata;
    logic [LA-1:0] list_raddr, list_waddr;
    logic          goto_we, fail_we, cnt_we;

    assign goto_raddr = {n_cur, n_byte};
    assign list_raddr = LA'(n_cur) * LA'(MATCHES_PER_NODE) + LA'(n_k);
    assign cnt_raddr  = acc_app ? in_node : n_cur;
    assign list_waddr = LA'(r_node) * LA'(MATCHES_PER_NODE) + LA'(cnt_rd);

    always_comb begin
        goto_we    = 1'b0;
        goto_waddr = {in_node, i_in.byte_value};
        goto_wdata = in_tgt;
        fail_we    = 1'b0;
        fail_waddr = in_node;
        fail_wdata = in_tgt;
        cnt_we     = 1'b0;
        cnt_waddr  = r_node;
        cnt_wdata  = cnt_rd + CW'(1);
        if (i_cmd.clr_step) begin
            // sweep every goto entry; node part of the sweep covers the per-node tables
            goto_we    = 1'b1;
            goto_waddr = r_clr;
            goto_wdata = '0;
            fail_we    = 1'b1;
            fail_waddr = r_clr[GA-1:8];
            fail_wdata = '0;
            cnt_we     = 1'b1;
            cnt_waddr  = r_clr[GA-1:8];
            cnt_wdata  = '0;
        end else begin
            goto_we = acc_goto && in_node_ok && in_tgt_ok;
            fail_we = acc_fail && in_node_ok && in_tgt_ok;
            cnt_we  = i_cmd.app_write;
        end
    end

    // Goto table
    always_ff @(posedge i_clk) begin
        if (goto_we) begin
            goto_mem[goto_waddr] <= goto_wdata;
        end
        goto_rd <= goto_mem[goto_raddr];
    end

    // Failure links
    always_ff @(posedge i_clk) begin
        if (fail_we) begin
            fail_mem[fail_waddr] <= fail_wdata;
        end
        fail_rd <= fail_mem[n_cur];
    end

    // Match counts
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rd <= cnt_mem[cnt_raddr];
    end

    // Match id lists
    always_ff @(posedge i_clk) begin
        if (i_cmd.app_write) begin
            list_mem[list_waddr] <= r_pid;
        end
        list_rd <= list_mem[list_raddr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_pos       <= '0;
            r_k         <= '0;
            r_steps     <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cur <= n_cur;
            r_k   <= n_k;
            if (acc_start) begin
                r_pos <= '0;
            end else if (i_cmd.scan_done) begin
                r_pos <= r_pos + POSITION_BITS'(1);
            end
            if (i_cmd.accept) begin
                r_steps <= '0;
            end else if (i_cmd.follow_fail) begin
                r_steps <= r_steps + SW'(1);
            end
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + GA'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Beat fields and result payload
    logic [POSITION_BITS+31:0] pos_x;
    assign pos_x = {32'd0, r_pos};

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        if (i_cmd.accept) begin
            r_node    <= in_node;
            r_node_ok <= in_node_ok;
            r_pid     <= i_in.pattern_id;
            r_pid_ok  <= in_pid_ok;
        end
        if (i_cmd.emit) begin
            r_out.position         <= pos_x[31:0];
            r_out.pattern_id_found <= list_rd;
            r_out.last_match       <= o_sts.last_k;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Status to the controller
    always_comb begin
        o_sts.clr_last  = (r_clr == GA'(GD - 1));
        o_sts.in_cmd    = i_in.command;
        o_sts.child_nz  = (goto_rd != '0);
        o_sts.cur_zero  = (r_cur == '0);
        o_sts.steps_max = (r_steps == SW'(NODES));
        o_sts.cnt_zero  = (cnt_rd == '0);
        o_sts.last_k    = ((r_k + CW'(1)) == cnt_rd);
        o_sts.out_free  = !r_out_valid || !i_out_stall;
        o_sts.app_ok    = r_node_ok && r_pid_ok && (cnt_rd < CW'(MATCHES_PER_NODE));
    end

    // Assertions
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over an untaken beat");

    a_child_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_child |=> (r_cur != '0))
        else $error("walk moved to the root as a child");

    a_steps_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps <= SW'(NODES))
        else $error("failure walk exceeded the node count");

    a_k_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_k < cnt_rd))
        else $error("match index beyond the node's list");

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// Testbench for multi_pattern_byte_matcher_core: loads Aho-Corasick node tables, scans bytes
// and checks each match beat against an automaton mirrored in the bench.
// Depends on mpbm_pkg and the RTL of the block only.
module tb;

    localparam int NODE_COUNT     = mpbm_pkg::DEF_NODES;
    localparam int MATCH_CAP      = mpbm_pkg::DEF_MATCHES_PER_NODE;
    localparam int ID_RANGE       = mpbm_pkg::DEF_PATTERN_IDS;
    // clearing pass alone sweeps NODES*256 goto entries with nothing taken
    localparam int WATCHDOG_LIMIT = 300000;
    localparam int TAIL_CYCLES    = 400;
    localparam int REPORT_LIMIT   = 10;

    // Command codes the block ignores
    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    mpbm_pkg::t_in_beat  i_in        = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    mpbm_pkg::t_out_beat o_out;

    // Beats waiting to be sent, match beats still owed by the block
    mpbm_pkg::t_in_beat  pending_beats [$];
    mpbm_pkg::t_out_beat due_matches [$];
    bit        beat_taken    = 1'b0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        err_count     = 0;
    int        quiet_cycles  = 0;

    // Mirror of the node tables and scan state
    logic [7:0]  child_tbl [0:NODE_COUNT*256-1];
    logic [7:0]  fail_tbl  [0:NODE_COUNT-1];
    int          id_cnt    [0:NODE_COUNT-1];
    logic [7:0]  id_list   [0:NODE_COUNT*MATCH_CAP-1];
    logic [7:0]  scan_node = 8'd0;
    logic [31:0] scan_pos  = 32'd0;

    multi_pattern_byte_matcher_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Apply one input beat to the mirrored automaton, queue the match beats it owes
    task automatic advance_automaton(input mpbm_pkg::t_in_beat b);
        logic [7:0]          cur;
        int                  steps;
        int                  k;
        mpbm_pkg::t_out_beat hit;
        case (b.command)
            mpbm_pkg::CMD_SCAN: begin
                cur   = scan_node;
                steps = 0;
                // failure walk, cut short at NODES links so a loop falls back to root
                while (cur != 8'd0 && child_tbl[{cur, b.byte_value}] == 8'd0) begin
                    if (steps >= NODE_COUNT) begin
                        cur = 8'd0;
                        break;
                    end
                    cur = fail_tbl[cur];
                    steps++;
                end
                if (child_tbl[{cur, b.byte_value}] != 8'd0)
                    cur = child_tbl[{cur, b.byte_value}];
                scan_node = cur;
                for (k = 0; k < id_cnt[cur]; k++) begin
                    hit.position         = scan_pos;
                    hit.pattern_id_found = id_list[cur * MATCH_CAP + k];
                    hit.last_match       = (k == id_cnt[cur] - 1);
                    due_matches          = {due_matches, hit};
                end
                scan_pos++;
            end
            mpbm_pkg::CMD_START: begin
                scan_node = 8'd0;
                scan_pos  = 32'd0;
            end
            mpbm_pkg::CMD_GOTO: begin
                if (b.node_index < NODE_COUNT && b.target_node < NODE_COUNT)
                    child_tbl[{b.node_index, b.byte_value}] = b.target_node;
            end
            mpbm_pkg::CMD_FAIL: begin
                if (b.node_index < NODE_COUNT && b.target_node < NODE_COUNT)
                    fail_tbl[b.node_index] = b.target_node;
            end
            mpbm_pkg::CMD_APPEND: begin
                // a full list drops further ids
                if (b.node_index < NODE_COUNT && b.pattern_id < ID_RANGE &&
                    id_cnt[b.node_index] < MATCH_CAP) begin
                    id_list[b.node_index * MATCH_CAP + id_cnt[b.node_index]] = b.pattern_id;
                    id_cnt[b.node_index]++;
                end
            end
            default: ;
        endcase
    endtask

    // Compare one match beat with the oldest one owed
    task automatic check_match(input mpbm_pkg::t_out_beat got);
        mpbm_pkg::t_out_beat want;
        if (due_matches.size() == 0) begin
            err_count++;
            if (err_count <= REPORT_LIMIT)
                $display("unexpected match beat: pos %0d id %0d last %0d",
                         got.position, got.pattern_id_found, got.last_match);
        end else begin
            want = due_matches.pop_front();
            if (got.position !== want.position ||
                got.pattern_id_found !== want.pattern_id_found ||
                got.last_match !== want.last_match) begin
                err_count++;
                if (err_count <= REPORT_LIMIT)
                    $display({"match beat differs: want pos %0d id %0d last %0d, ",
                              "got pos %0d id %0d last %0d"},
                             want.position, want.pattern_id_found, want.last_match,
                             got.position, got.pattern_id_found, got.last_match);
            end
        end
    endtask

    // Monitor: sample both handshakes at the rising edge, plus the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet_cycles++;
            if (o_out_valid && !i_out_stall) begin
                check_match(o_out);
                quiet_cycles = 0;
            end
            if (i_in_valid && !o_in_stall) begin
                advance_automaton(i_in);
                pending_beats.delete(0);
                beat_taken   = 1'b1;
                quiet_cycles = 0;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    // Driver: change inputs at the falling edge, hold a beat until it is taken
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || beat_taken) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in       <= pending_beats[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
        beat_taken = 1'b0;
    end

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    function automatic void push_beat(input logic [2:0] cmd, input logic [7:0] node,
                                      input logic [7:0] value, input logic [7:0] target,
                                      input logic [7:0] pid);
        mpbm_pkg::t_in_beat b;
        b.command     = cmd;
        b.node_index  = node;
        b.byte_value  = value;
        b.target_node = target;
        b.pattern_id  = pid;
        pending_beats = {pending_beats, b};
    endfunction

    task automatic wait_drained();
        while (pending_beats.size() != 0 || due_matches.size() != 0)
            @(negedge i_clk);
    endtask

    // Build a small random trie over a four-byte alphabet, then scan text mostly
    // drawn from that alphabet with some stray bytes, restarts and table noise
    task automatic random_phase(input int send_pct, input int recv_pct, input int n_beats);
        logic [7:0] sym [0:3];
        logic [7:0] ids [0:9];
        int         nn;
        int         i;
        int         j;
        int         sent;
        int         pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (i = 0; i < 4; i++)
            sym[i] = rnd8();
        nn     = $urandom_range(5, 10);
        ids[0] = 8'd0;
        for (i = 1; i < nn; i++)
            ids[i] = 8'($urandom_range(1, 255));
        sent = 0;
        for (i = 1; i < nn; i++) begin
            push_beat(mpbm_pkg::CMD_GOTO, ids[$urandom_range(0, i - 1)],
                      sym[$urandom_range(0, 3)], ids[i], rnd8());
            push_beat(mpbm_pkg::CMD_FAIL, ids[i], rnd8(), ids[$urandom_range(0, i - 1)],
                      rnd8());
            sent += 2;
            if ($urandom_range(1) != 0) begin
                for (j = $urandom_range(1, 3); j > 0; j--) begin
                    push_beat(mpbm_pkg::CMD_APPEND, ids[i], rnd8(), rnd8(), rnd8());
                    sent++;
                end
            end
        end
        while (sent < n_beats) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                push_beat(mpbm_pkg::CMD_SCAN, rnd8(), sym[$urandom_range(0, 3)], rnd8(),
                          rnd8());
            end else if (pick < 88) begin
                push_beat(mpbm_pkg::CMD_SCAN, rnd8(), rnd8(), rnd8(), rnd8());
            end else if (pick < 93) begin
                push_beat(mpbm_pkg::CMD_START, rnd8(), rnd8(), rnd8(), rnd8());
            end else if (pick < 96) begin
                push_beat(mpbm_pkg::CMD_APPEND, ids[$urandom_range(0, nn - 1)], rnd8(),
                          rnd8(), rnd8());
            end else if (pick < 98) begin
                push_beat(mpbm_pkg::CMD_GOTO, rnd8(), rnd8(), rnd8(), rnd8());
            end else begin
                // ignored beat, not counted
                push_beat(3'($urandom_range(CMD_RSVD5, CMD_RSVD7)),
                          rnd8(), rnd8(), rnd8(), rnd8());
                sent--;
            end
            sent++;
        end
        wait_drained();
    endtask

    initial begin : stimulus
        int i;
        for (i = 0; i < NODE_COUNT * 256; i++)
            child_tbl[i] = 8'd0;
        for (i = 0; i < NODE_COUNT; i++) begin
            fail_tbl[i] = 8'd0;
            id_cnt[i]   = 0;
        end
        for (i = 0; i < NODE_COUNT * MATCH_CAP; i++)
            id_list[i] = 8'd0;
        send_idle_pct = 35;
        recv_idle_pct = 64;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty root gives nothing; then a root child carrying ids at both extremes
        push_beat(mpbm_pkg::CMD_SCAN,   rnd8(), 8'h00, rnd8(), rnd8());
        push_beat(mpbm_pkg::CMD_GOTO,   8'd0,   8'h41, 8'd1,   rnd8());
        push_beat(mpbm_pkg::CMD_APPEND, 8'd1,   rnd8(), rnd8(), 8'h00);
        push_beat(mpbm_pkg::CMD_APPEND, 8'd1,   rnd8(), rnd8(), 8'hFF);
        push_beat(mpbm_pkg::CMD_SCAN,   rnd8(), 8'h41, rnd8(), rnd8());
        // node 255 fails to itself: the walk is cut short and lands on root
        push_beat(mpbm_pkg::CMD_GOTO,   8'hFF,  8'hFF, 8'hFF,  rnd8());
        push_beat(mpbm_pkg::CMD_FAIL,   8'hFF,  rnd8(), 8'hFF, rnd8());
        push_beat(mpbm_pkg::CMD_GOTO,   8'd1,   8'hFF, 8'hFF,  rnd8());
        push_beat(mpbm_pkg::CMD_SCAN,   rnd8(), 8'hFF, rnd8(), rnd8());
        push_beat(mpbm_pkg::CMD_SCAN,   rnd8(), 8'h10, rnd8(), rnd8());
        // one append more than a list holds; the last is dropped
        for (i = 1; i <= MATCH_CAP + 1; i++)
            push_beat(mpbm_pkg::CMD_APPEND, 8'd2, rnd8(), rnd8(), 8'(i));
        push_beat(mpbm_pkg::CMD_GOTO,   8'd0,   8'h42, 8'd2,   rnd8());
        push_beat(mpbm_pkg::CMD_SCAN,   rnd8(), 8'h42, rnd8(), rnd8());
        // restart puts the position back to zero, tables kept
        push_beat(mpbm_pkg::CMD_START,  rnd8(), rnd8(), rnd8(), rnd8());
        push_beat(mpbm_pkg::CMD_SCAN,   rnd8(), 8'h41, rnd8(), rnd8());
        push_beat(CMD_RSVD5,  8'hFF,  8'hFF, 8'hFF,  8'hFF);
        push_beat(CMD_RSVD6,  8'hFF,  8'hFF, 8'hFF,  8'hFF);
        push_beat(CMD_RSVD7,  8'hFF,  8'hFF, 8'hFF,  8'hFF);
        wait_drained();

        random_phase(35, 64, 75);
        random_phase(64, 35, 75);
        random_phase(0, 0, 75);

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
